// ===== hdl/grid_bfs_shortest_path_defines.svh =====
// Assertion macros shared by the grid shortest-path search block.
`ifndef GRID_BFS_SHORTEST_PATH_DEFINES_SVH
`define GRID_BFS_SHORTEST_PATH_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/gbsp_pkg.sv =====
// Types and constants of the grid shortest-path search block.
package gbsp_pkg;

    localparam int ROW_W  = 6;
    localparam int DIST_W = 12;
    localparam int WORD_W = 64;
    localparam int SIZE_W = 7;

    typedef logic [ROW_W-1:0]  t_coord;
    typedef logic [DIST_W-1:0] t_dist;

    typedef struct packed {
        t_coord row;
        t_coord col;
        t_dist  steps;
    } t_q_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_POP,
        S_ENTRY,
        S_NADDR,
        S_NTEST
    } t_state;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;
    localparam logic [1:0] DIR_LAST  = DIR_RIGHT;

    localparam logic [1:0] REG_GRID_SIZE  = 2'd0;
    localparam logic [1:0] REG_TARGET_ROW = 2'd1;
    localparam logic [1:0] REG_TARGET_COL = 2'd2;

    localparam logic [SIZE_W-1:0] GRID_SIZE_RST = 7'd64;

    typedef struct packed {
        logic load;
        logic srch_init;
        logic clr_step;
        logic pop;
        logic entry;
        logic nb_read;
        logic nb_push;
        logic k_inc;
        logic done_hit;
        logic done_miss;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic q_empty;
        logic hit;
        logic nb_in;
        logic nb_open;
        logic k_last;
    } t_dp_sts;

endpackage

// ===== hdl/grid_bfs_shortest_path.sv =====
// Load: writes one wall row and gives no result. Search: clears the visited map row by row,
// then for each dequeued cell checks its four neighbors, reading the wall and visited maps
// (each with a single read port) only for a neighbor inside the grid; the result strobe is
// registered from the final search state.
// One item at a time; busy stays high until the result is shown and the receiver cannot stall.
// Synchronous active-low reset returns to idle with grid_size 64 and target (0,0).
`include "grid_bfs_shortest_path_defines.svh"

module grid_bfs_shortest_path
    import gbsp_pkg::*;
#(
    parameter int MAX_SIZE = 64
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_action,
    input  logic [5:0]        i_row_index,
    input  logic [63:0]       i_wall_bits,
    output logic              o_valid,
    output logic              o_reached,
    output logic [11:0]       o_distance,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [SIZE_W-1:0] r_grid_size;
    t_coord            r_target_row;
    t_coord            r_target_col;
    logic              w_cfg_wr;
    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size  <= GRID_SIZE_RST;
            r_target_row <= '0;
            r_target_col <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_GRID_SIZE:  r_grid_size  <= pwdata[SIZE_W-1:0];
                REG_TARGET_ROW: r_target_row <= pwdata[ROW_W-1:0];
                REG_TARGET_COL: r_target_col <= pwdata[ROW_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_GRID_SIZE:  prdata = 32'(r_grid_size);
            REG_TARGET_ROW: prdata = 32'(r_target_row);
            REG_TARGET_COL: prdata = 32'(r_target_col);
            default:        prdata = '0;
        endcase
    end

    gbsp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    gbsp_dp #(
        .MAX_SIZE (MAX_SIZE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_row_index  (i_row_index),
        .i_wall_bits  (i_wall_bits),
        .i_grid_size  (r_grid_size),
        .i_target_row (r_target_row),
        .i_target_col (r_target_col),
        .o_valid      (o_valid),
        .o_reached    (o_reached),
        .o_distance   (o_distance)
    );

    `ASSERT_IMPL(a_strobe_idle, i_clk, i_rst_n, o_valid, !busy)
    `ASSERT_NEXT(a_search_busy, i_clk, i_rst_n, start && !busy && i_action == ACT_SEARCH, busy)
    `ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, start && !busy && i_action == ACT_LOAD, !o_valid)
    `ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n, o_valid && !o_reached, o_distance == '0)

endmodule

// ===== hdl/gbsp_ctrl.sv =====
// Search sequencer: clears the visited map, then pops cells and checks neighbors.
module gbsp_ctrl
    import gbsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_action,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_action == ACT_SEARCH) begin
                        o_cmd.srch_init = 1'b1;
                        n_state         = S_CLEAR;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (i_sts.q_empty) begin
                    o_cmd.done_miss = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_ENTRY;
                end
            end
            S_ENTRY: begin
                if (i_sts.hit) begin
                    o_cmd.done_hit = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.entry = 1'b1;
                    n_state     = S_NADDR;
                end
            end
            S_NADDR: begin
                // skip neighbors outside the grid without a map read
                if (i_sts.nb_in) begin
                    o_cmd.nb_read = 1'b1;
                    n_state       = S_NTEST;
                end else if (i_sts.k_last) begin
                    n_state = S_POP;
                end else begin
                    o_cmd.k_inc = 1'b1;
                end
            end
            S_NTEST: begin
                if (i_sts.nb_open) begin
                    o_cmd.nb_push = 1'b1;
                end
                if (i_sts.k_last) begin
                    n_state = S_POP;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_NADDR;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== hdl/gbsp_dp.sv =====
// Datapath: wall map, visited map, frontier queue, pointers and result registers.
module gbsp_dp
    import gbsp_pkg::*;
#(
    parameter int MAX_SIZE = 64
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  t_coord            i_row_index,
    input  logic [WORD_W-1:0] i_wall_bits,
    input  logic [SIZE_W-1:0] i_grid_size,
    input  t_coord            i_target_row,
    input  t_coord            i_target_col,
    output logic              o_valid,
    output logic              o_reached,
    output t_dist             o_distance
);

    localparam int RW = $clog2(MAX_SIZE);
    localparam int QD = MAX_SIZE * MAX_SIZE;
    localparam int QW = $clog2(QD);

    logic [WORD_W-1:0] r_wall_mem [MAX_SIZE];
    logic [WORD_W-1:0] r_vis_mem  [MAX_SIZE];
    t_q_entry          r_queue    [QD];

    logic [WORD_W-1:0] r_wall_rd;
    logic [WORD_W-1:0] r_vis_rd;
    t_q_entry          r_q_rd;
    t_q_entry          r_cur;
    t_coord            r_nr;
    t_coord            r_nc;
    logic [RW-1:0]     r_clr_cnt;
    logic [QW:0]       r_head;
    logic [QW:0]       r_tail;
    logic [1:0]        r_k;
    logic              r_valid;
    logic              r_reached;
    t_dist             r_dist;

    logic [SIZE_W-1:0] w_n;
    logic              w_nb_in;
    t_coord            w_nb_row;
    t_coord            w_nb_col;
    logic              w_load_ok;
    t_q_entry          w_push;

    // saturate the grid size into 1..MAX_SIZE
    always_comb begin
        if (i_grid_size == '0) begin
            w_n = SIZE_W'(1);
        end else if (i_grid_size > SIZE_W'(MAX_SIZE)) begin
            w_n = SIZE_W'(MAX_SIZE);
        end else begin
            w_n = i_grid_size;
        end
    end

    always_comb begin
        w_nb_row = r_cur.row;
        w_nb_col = r_cur.col;
        w_nb_in  = 1'b0;
        case (r_k)
            DIR_UP: begin
                w_nb_in  = (r_cur.row != '0);
                w_nb_row = r_cur.row - 6'd1;
            end
            DIR_DOWN: begin
                w_nb_in  = (({1'b0, r_cur.row} + 7'd1) < w_n);
                w_nb_row = r_cur.row + 6'd1;
            end
            DIR_LEFT: begin
                w_nb_in  = (r_cur.col != '0);
                w_nb_col = r_cur.col - 6'd1;
            end
            DIR_RIGHT: begin
                w_nb_in  = (({1'b0, r_cur.col} + 7'd1) < w_n);
                w_nb_col = r_cur.col + 6'd1;
            end
            default: begin
                w_nb_in = 1'b0;
            end
        endcase
    end

    assign w_load_ok = ({1'b0, i_row_index} < SIZE_W'(MAX_SIZE));
    assign w_push    = '{row: r_nr, col: r_nc, steps: r_cur.steps + 12'd1};

    // wall map: written by load items, read one row per neighbor check inside the grid
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_load_ok) begin
            r_wall_mem[i_row_index[RW-1:0]] <= i_wall_bits;
        end
        if (i_cmd.nb_read) begin
            r_wall_rd <= r_wall_mem[w_nb_row[RW-1:0]];
        end
    end

    // visited map: cleared row by row, start cell marked on row zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_vis_mem[r_clr_cnt] <= (r_clr_cnt == '0) ? WORD_W'(1) : '0;
        end else if (i_cmd.nb_push) begin
            r_vis_mem[r_nr[RW-1:0]] <= r_vis_rd | (WORD_W'(1) << r_nc);
        end
        if (i_cmd.nb_read) begin
            r_vis_rd <= r_vis_mem[w_nb_row[RW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_init) begin
            r_queue[QW'(0)] <= '0;
        end else if (i_cmd.nb_push) begin
            r_queue[r_tail[QW-1:0]] <= w_push;
        end
        if (i_cmd.pop) begin
            r_q_rd <= r_queue[r_head[QW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.entry) begin
            r_cur <= r_q_rd;
        end
        if (i_cmd.nb_read) begin
            r_nr <= w_nb_row;
            r_nc <= w_nb_col;
        end
        if (i_cmd.done_hit) begin
            r_dist <= r_q_rd.steps;
        end else if (i_cmd.done_miss) begin
            r_dist <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_k       <= DIR_UP;
            r_valid   <= 1'b0;
            r_reached <= 1'b0;
        end else begin
            r_valid <= i_cmd.done_hit | i_cmd.done_miss;
            if (i_cmd.done_hit | i_cmd.done_miss) begin
                r_reached <= i_cmd.done_hit;
            end
            if (i_cmd.srch_init) begin
                r_clr_cnt <= '0;
                r_head    <= '0;
                r_tail    <= (QW+1)'(1);
            end else begin
                if (i_cmd.clr_step) begin
                    r_clr_cnt <= r_clr_cnt + RW'(1);
                end
                if (i_cmd.pop) begin
                    r_head <= r_head + (QW+1)'(1);
                end
                if (i_cmd.nb_push) begin
                    r_tail <= r_tail + (QW+1)'(1);
                end
            end
            if (i_cmd.entry) begin
                r_k <= DIR_UP;
            end else if (i_cmd.k_inc) begin
                r_k <= r_k + 2'd1;
            end
        end
    end

    assign o_sts.clr_last = (r_clr_cnt == RW'(MAX_SIZE - 1));
    assign o_sts.q_empty  = (r_head == r_tail);
    assign o_sts.hit      = (r_q_rd.row == i_target_row) && (r_q_rd.col == i_target_col);
    assign o_sts.nb_in    = w_nb_in;
    assign o_sts.nb_open  = !r_vis_rd[r_nc] && !r_wall_rd[r_nc];
    assign o_sts.k_last   = (r_k == DIR_LAST);

    assign o_valid    = r_valid;
    assign o_reached  = r_reached;
    assign o_distance = r_dist;

endmodule
